[rtl/resp_reply_tokenizer_top_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the reply tokenizer
// Concurrent checks sampled on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef RESP_REPLY_TOKENIZER_TOP_MACROS_SVH
`define RESP_REPLY_TOKENIZER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RRT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RRT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/rrt_pkg.sv]
// ---------------------------------------------------------------------------
// Reply tokenizer package
// Event and reply type codes, protocol byte constants, result word type.
// ---------------------------------------------------------------------------
package rrt_pkg;

    typedef enum logic [2:0] {
        EV_HEADER      = 3'd0,
        EV_LINE_START  = 3'd1,
        EV_CONTENT     = 3'd2,
        EV_REPLY_END   = 3'd3,
        EV_BAD_TYPE    = 3'd4
    } event_e;

    typedef enum logic [3:0] {
        RT_BULK      = 4'd0,
        RT_SIMPLE    = 4'd1,
        RT_ERROR     = 4'd2,
        RT_INTEGER   = 4'd3,
        RT_ARRAY     = 4'd4,
        RT_SET       = 4'd5,
        RT_MAP       = 4'd6,
        RT_BOOL      = 4'd7,
        RT_DOUBLE    = 4'd8,
        RT_NULL      = 4'd9,
        RT_BIGNUM    = 4'd10,
        RT_VERBATIM  = 4'd11,
        RT_ATTRIBUTE = 4'd12
    } rtype_e;

    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_TILDE   = 8'h7E;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_PIPE    = 8'h7C;
    localparam logic [7:0] CH_LOWER_T = 8'h74;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    localparam logic signed [63:0] NIL_LENGTH = -64'sd1;

    typedef struct packed {
        logic        known;
        rtype_e      rtype;
    } type_lookup_t;

    typedef struct packed {
        logic               valid;
        event_e             event_res;
        rtype_e             reply_type;
        logic signed [63:0] header_value;
        logic               is_nil;
        logic               header_completes;
        logic [7:0]         content_byte;
        logic               in_format;
        logic               bad_number;
    } rrt_result_t;

    // Map a type byte to its reply type.
    function automatic type_lookup_t type_lookup(input logic [7:0] b);
        type_lookup_t r;
        r.known = 1'b1;
        r.rtype = RT_BULK;
        unique case (b)
            CH_DOLLAR:  r.rtype = RT_BULK;
            CH_PLUS:    r.rtype = RT_SIMPLE;
            CH_MINUS:   r.rtype = RT_ERROR;
            CH_COLON:   r.rtype = RT_INTEGER;
            CH_STAR:    r.rtype = RT_ARRAY;
            CH_TILDE:   r.rtype = RT_SET;
            CH_PERCENT: r.rtype = RT_MAP;
            CH_HASH:    r.rtype = RT_BOOL;
            CH_COMMA:   r.rtype = RT_DOUBLE;
            CH_UNDER:   r.rtype = RT_NULL;
            CH_LPAREN:  r.rtype = RT_BIGNUM;
            CH_EQUAL:   r.rtype = RT_VERBATIM;
            CH_PIPE:    r.rtype = RT_ATTRIBUTE;
            default:    r.known = 1'b0;
        endcase
        return r;
    endfunction

endpackage

[rtl/rrt_byte_if.sv]
// ---------------------------------------------------------------------------
// Reply byte channel
// Valid/ready channel carrying one reply stream byte per word.
// ---------------------------------------------------------------------------
interface rrt_byte_if;

    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);

endinterface

[rtl/rrt_event_if.sv]
// ---------------------------------------------------------------------------
// Tokenizer event channel
// Valid/ready channel carrying one tokenizer event per word.
// ---------------------------------------------------------------------------
interface rrt_event_if;

    logic               valid;
    logic               ready;
    logic [2:0]         event_res;
    logic [3:0]         reply_type;
    logic signed [63:0] header_value;
    logic               is_nil;
    logic               header_completes;
    logic [7:0]         content_byte;
    logic               in_format;
    logic               bad_number;

    modport source (
        output valid, output event_res, output reply_type, output header_value,
        output is_nil, output header_completes, output content_byte,
        output in_format, output bad_number, input ready
    );
    modport sink (
        input valid, input event_res, input reply_type, input header_value,
        input is_nil, input header_completes, input content_byte,
        input in_format, input bad_number, output ready
    );

endinterface

[rtl/rrt_core.sv]
// ---------------------------------------------------------------------------
// Reply tokenizer core
// Parser state and the per-byte next-state and event logic.
// ---------------------------------------------------------------------------
module rrt_core #(
    parameter int LENGTH_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          stream_byte,
    output rrt_pkg::rrt_result_t result
);
    import rrt_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_NUM_FIRST  = 4'd1,
        PH_NUM_SIGN   = 4'd2,
        PH_NUM_ZERO   = 4'd3,
        PH_NUM_DIGITS = 4'd4,
        PH_NUM_LF     = 4'd5,
        PH_LINE       = 4'd6,
        PH_LINE_LF    = 4'd7,
        PH_TAIL_FIRST = 4'd8,
        PH_TAIL       = 4'd9,
        PH_TAIL_LF    = 4'd10,
        PH_BODY       = 4'd11,
        PH_BODY_CR    = 4'd12,
        PH_BODY_LF    = 4'd13
    } phase_e;

    localparam logic [63:0] LenMax = 64'((65'd1 << LENGTH_BITS) - 65'd1);
    localparam logic [67:0] PosLimit = 68'h0_7FFF_FFFF_FFFF_FFFF;
    localparam logic [67:0] NegLimit = 68'h0_8000_0000_0000_0000;

    phase_e                 phase_reg, phase_next;
    rtype_e                 type_reg, type_next;
    logic [63:0]            accum_reg, accum_next;
    logic                   neg_reg, neg_next;
    logic                   invalid_reg, invalid_next;
    logic [LENGTH_BITS-1:0] left_reg, left_next;
    logic [2:0]             fmt_idx_reg, fmt_idx_next;
    logic                   seen_true_reg, seen_true_next;

    logic                   is_digit;
    logic [3:0]             digit_val;
    logic [67:0]            acc_scaled;
    logic                   acc_overflow;
    type_lookup_t           lookup;
    logic                   number_ok;
    logic                   minus_one;
    logic signed [63:0]     number_val;
    logic [LENGTH_BITS-1:0] left_dec;
    logic                   fmt_flag;

    // accum*10 + digit as two shifts and two adds; overflow is a compare against the limit
    assign is_digit     = (stream_byte >= CH_ZERO) && (stream_byte <= CH_NINE);
    assign digit_val    = stream_byte[3:0];
    assign acc_scaled   = ({4'd0, accum_reg} << 3) + ({4'd0, accum_reg} << 1)
                        + {64'd0, digit_val};
    assign acc_overflow = acc_scaled > (neg_reg ? NegLimit : PosLimit);

    assign lookup     = type_lookup(stream_byte);
    assign number_ok  = !invalid_reg;
    assign minus_one  = number_ok && neg_reg && (accum_reg == 64'd1);
    assign number_val = !number_ok ? 64'sd0
                      : (neg_reg ? $signed(64'd0 - accum_reg) : $signed(accum_reg));
    assign left_dec   = left_reg - LENGTH_BITS'(1);
    assign fmt_flag   = (type_reg == RT_VERBATIM) && (fmt_idx_reg < 3'd4);

    always_comb
    begin
        phase_next     = phase_reg;
        type_next      = type_reg;
        accum_next     = accum_reg;
        neg_next       = neg_reg;
        invalid_next   = invalid_reg;
        left_next      = left_reg;
        fmt_idx_next   = fmt_idx_reg;
        seen_true_next = seen_true_reg;
        result            = '0;
        result.reply_type = type_reg;

        unique case (phase_reg)
            PH_NUM_FIRST, PH_NUM_SIGN, PH_NUM_ZERO, PH_NUM_DIGITS:
            begin
                priority if (stream_byte == CH_CR)
                begin
                    if (phase_reg == PH_NUM_FIRST || phase_reg == PH_NUM_SIGN)
                        invalid_next = 1'b1;
                    phase_next = PH_NUM_LF;
                end
                else if (invalid_reg)
                    phase_next = PH_NUM_DIGITS;
                else if (phase_reg == PH_NUM_FIRST && stream_byte == CH_MINUS)
                begin
                    neg_next   = 1'b1;
                    phase_next = PH_NUM_SIGN;
                end
                else if (phase_reg == PH_NUM_FIRST && stream_byte == CH_ZERO)
                    phase_next = PH_NUM_ZERO;
                else if (is_digit && phase_reg != PH_NUM_ZERO
                         && (phase_reg == PH_NUM_DIGITS || digit_val != 4'd0))
                begin
                    if (acc_overflow)
                        invalid_next = 1'b1;
                    else
                        accum_next = acc_scaled[63:0];
                    phase_next = PH_NUM_DIGITS;
                end
                else
                begin
                    invalid_next = 1'b1;
                    phase_next   = PH_NUM_DIGITS;
                end
            end

            PH_NUM_LF:
            begin
                phase_next          = PH_IDLE;
                result.valid        = 1'b1;
                result.event_res    = EV_HEADER;
                result.header_value = number_val;
                priority if (type_reg == RT_INTEGER)
                begin
                    result.header_completes = 1'b1;
                    result.bad_number       = !number_ok;
                end
                else if (type_reg == RT_BULK || type_reg == RT_VERBATIM)
                begin
                    priority if (type_reg == RT_BULK && minus_one)
                    begin
                        result.is_nil           = 1'b1;
                        result.header_completes = 1'b1;
                    end
                    else if (!number_ok || neg_reg || accum_reg > LenMax)
                    begin
                        result.header_completes = 1'b1;
                        result.bad_number       = 1'b1;
                    end
                    else
                    begin
                        left_next    = accum_reg[LENGTH_BITS-1:0];
                        fmt_idx_next = 3'd0;
                        phase_next   = (accum_reg != 64'd0) ? PH_BODY : PH_BODY_CR;
                    end
                end
                else if (type_reg == RT_ARRAY && minus_one)
                begin
                    result.is_nil           = 1'b1;
                    result.header_completes = 1'b1;
                end
                else
                begin
                    result.header_completes = 1'b1;
                    result.bad_number       = !number_ok || neg_reg;
                end
            end

            PH_LINE:
            begin
                if (stream_byte == CH_CR)
                    phase_next = PH_LINE_LF;
                else
                begin
                    result.valid        = 1'b1;
                    result.event_res    = EV_CONTENT;
                    result.content_byte = stream_byte;
                end
            end

            PH_LINE_LF, PH_BODY_LF:
            begin
                phase_next       = PH_IDLE;
                result.valid     = 1'b1;
                result.event_res = EV_REPLY_END;
            end

            PH_TAIL_FIRST:
            begin
                if (stream_byte == CH_CR)
                    phase_next = PH_TAIL_LF;
                else
                begin
                    seen_true_next = (stream_byte == CH_LOWER_T);
                    phase_next     = PH_TAIL;
                end
            end

            PH_TAIL:
            begin
                if (stream_byte == CH_CR)
                    phase_next = PH_TAIL_LF;
            end

            PH_TAIL_LF:
            begin
                phase_next              = PH_IDLE;
                result.valid            = 1'b1;
                result.event_res        = EV_HEADER;
                result.header_completes = 1'b1;
                result.header_value     = {63'd0, (type_reg == RT_BOOL) && seen_true_reg};
            end

            PH_BODY:
            begin
                if (fmt_flag)
                    fmt_idx_next = fmt_idx_reg + 3'd1;
                left_next = left_dec;
                if (left_dec == '0)
                    phase_next = PH_BODY_CR;
                result.valid        = 1'b1;
                result.event_res    = EV_CONTENT;
                result.content_byte = stream_byte;
                result.in_format    = fmt_flag;
            end

            PH_BODY_CR:
                phase_next = PH_BODY_LF;

            // idle, and any unused phase code: decode a type byte
            default:
            begin
                phase_next = PH_IDLE;
                if (!lookup.known)
                begin
                    result.valid      = 1'b1;
                    result.event_res  = EV_BAD_TYPE;
                    result.reply_type = RT_BULK;
                end
                else
                begin
                    type_next      = lookup.rtype;
                    accum_next     = 64'd0;
                    neg_next       = 1'b0;
                    invalid_next   = 1'b0;
                    seen_true_next = 1'b0;
                    unique case (lookup.rtype)
                        RT_SIMPLE, RT_ERROR, RT_DOUBLE, RT_BIGNUM:
                        begin
                            phase_next        = PH_LINE;
                            result.valid      = 1'b1;
                            result.event_res  = EV_LINE_START;
                            result.reply_type = lookup.rtype;
                        end
                        RT_BOOL: phase_next = PH_TAIL_FIRST;
                        RT_NULL: phase_next = PH_TAIL;
                        default: phase_next = PH_NUM_FIRST;
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            type_reg      <= RT_BULK;
            accum_reg     <= 64'd0;
            neg_reg       <= 1'b0;
            invalid_reg   <= 1'b0;
            left_reg      <= '0;
            fmt_idx_reg   <= 3'd0;
            seen_true_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            type_reg      <= type_next;
            accum_reg     <= accum_next;
            neg_reg       <= neg_next;
            invalid_reg   <= invalid_next;
            left_reg      <= left_next;
            fmt_idx_reg   <= fmt_idx_next;
            seen_true_reg <= seen_true_next;
        end
    end

endmodule

[rtl/resp_reply_tokenizer_top.sv]
// ---------------------------------------------------------------------------
// RESP2/RESP3 reply tokenizer, top level
// Turns a reply byte stream into header, text, content, end and error events.
// ---------------------------------------------------------------------------
// The tokenizer takes one reply byte per cycle on the stream channel while
// no blocked event holds it, and gives at most one event per byte on the
// events channel. Every byte passes an input register, parser logic that
// updates the state and forms the event, and an output register. A new byte
// is taken while the last event is still registered, so the unstalled rate
// is one byte per clock. The cycle budget is set by the multiply-by-ten
// accumulate and overflow compare of the 64-bit header number. Bytes that
// give no event (line ends, number digits) pass without touching the output
// register. When an event waits in the output register, the next byte is
// still taken and only stalls if it too yields an event. Aggregate headers
// report their element count only; nesting is tracked by the consumer.
// Bulk and verbatim lengths above 2^LENGTH_BITS-1 are flagged as bad numbers.
// stream.ready depends combinationally on events.ready.
// ---------------------------------------------------------------------------
`include "resp_reply_tokenizer_top_macros.svh"

module resp_reply_tokenizer_top #(
    parameter int LENGTH_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    rrt_byte_if.sink            stream,
    rrt_event_if.source         events
);
    import rrt_pkg::*;

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg, out_valid_next;
    rrt_result_t out_data_reg;

    rrt_result_t core_result;
    logic        advance;

    // Advance the held byte unless it makes an event and the output is full and stalled.
    assign advance = in_valid_reg
                   && (!core_result.valid || !out_valid_reg || events.ready);

    assign stream.ready = !in_valid_reg || advance;

    rrt_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .stream_byte (in_byte_reg),
        .result      (core_result)
    );

    always_comb
    begin
        in_valid_next = stream.valid || (in_valid_reg && !advance);
        priority if (advance && core_result.valid)
            out_valid_next = 1'b1;
        else if (events.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: load the byte on accept, the event when it is produced.
    always_ff @(posedge clk)
    begin
        if (stream.valid && stream.ready)
            in_byte_reg <= stream.stream_byte;
        if (advance && core_result.valid)
            out_data_reg <= core_result;
    end

    assign events.valid            = out_valid_reg;
    assign events.event_res        = out_data_reg.event_res;
    assign events.reply_type       = out_data_reg.reply_type;
    assign events.header_value     = out_data_reg.header_value;
    assign events.is_nil           = out_data_reg.is_nil;
    assign events.header_completes = out_data_reg.header_completes;
    assign events.content_byte     = out_data_reg.content_byte;
    assign events.in_format        = out_data_reg.in_format;
    assign events.bad_number       = out_data_reg.bad_number;

    // Only header words carry a value or error flag.
    `RRT_ASSERT_NOW(a_value_only_on_header,
        out_valid_reg && out_data_reg.event_res != EV_HEADER,
        out_data_reg.header_value == 64'sd0 && !out_data_reg.bad_number,
        "header value or bad number on a non-header word")

    // Format flag only on verbatim content bytes.
    `RRT_ASSERT_NOW(a_format_on_verbatim,
        out_valid_reg && out_data_reg.in_format,
        out_data_reg.event_res == EV_CONTENT && out_data_reg.reply_type == RT_VERBATIM,
        "format flag outside verbatim content")

    // A nil header carries length -1 and ends its reply.
    `RRT_ASSERT_NOW(a_nil_is_minus_one,
        out_valid_reg && out_data_reg.is_nil,
        out_data_reg.header_value == NIL_LENGTH && out_data_reg.header_completes,
        "nil header without length -1 or completion")

    // A byte whose event is blocked stays in the input register.
    `RRT_ASSERT_NEXT(a_hold_blocked_byte,
        in_valid_reg && core_result.valid && out_valid_reg && !events.ready,
        in_valid_reg && $stable(in_byte_reg),
        "blocked byte dropped from input register")

endmodule

[dv/tb_resp_reply_tokenizer_top.sv]
// ---------------------------------------------------------------------------
// Reply tokenizer testbench
// Feeds RESP2/RESP3 reply byte streams into the tokenizer and checks every
// event word against a cycle-free model of the parser kept in the bench.
// ---------------------------------------------------------------------------
package reply_token_pkg;

    import rrt_pkg::*;

    localparam int          LEN_BITS = 32;
    localparam logic [63:0] LEN_MASK = {64{1'b1}} >> (64 - LEN_BITS);
    localparam logic [63:0] POS_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG_MAX  = 64'h8000_0000_0000_0000;

    typedef enum logic [3:0] {
        P_IDLE,
        P_NUM_FIRST,
        P_NUM_SIGN,
        P_NUM_ZERO,
        P_NUM_DIGITS,
        P_NUM_LF,
        P_LINE,
        P_LINE_LF,
        P_TAIL_FIRST,
        P_TAIL,
        P_TAIL_LF,
        P_BODY,
        P_BODY_CR,
        P_BODY_LF
    } parse_phase_e;

    typedef struct packed {
        logic [2:0]  ev;
        logic [3:0]  rt;
        logic [63:0] value;
        logic        nil;
        logic        completes;
        logic [7:0]  text;
        logic        fmt;
        logic        bad;
    } token_t;

    class reply_token_tracker;

        parse_phase_e phase;
        rtype_e       cur_type;
        logic [63:0]  magnitude;
        bit           negative;
        bit           malformed;
        logic [63:0]  remaining;
        int unsigned  fmt_count;
        bit           saw_true;

        token_t       tokens_due[$];
        int unsigned  tokens_seen;
        int unsigned  error_count;

        function new();
            phase       = P_IDLE;
            cur_type    = RT_BULK;
            magnitude   = '0;
            negative    = 1'b0;
            malformed   = 1'b0;
            remaining   = '0;
            fmt_count   = 0;
            saw_true    = 1'b0;
            tokens_seen = 0;
            error_count = 0;
        endfunction

        function void add_token(event_e ev, rtype_e rt, logic [63:0] value, bit nil,
                                bit completes, logic [7:0] text, bit fmt, bit bad);
            token_t t;
            t.ev        = ev;
            t.rt        = rt;
            t.value     = value;
            t.nil       = nil;
            t.completes = completes;
            t.text      = text;
            t.fmt       = fmt;
            t.bad       = bad;
            tokens_due.push_back(t);
        endfunction

        // Close a header number on the byte after its CR.
        function void close_number();
            bit          ok;
            bit          minus_one;
            logic [63:0] val;
            ok        = !malformed;
            val       = ok ? (negative ? 64'd0 - magnitude : magnitude) : 64'd0;
            minus_one = ok && negative && (magnitude == 64'd1);
            phase     = P_IDLE;
            if (cur_type == RT_INTEGER) begin
                add_token(EV_HEADER, cur_type, val, 1'b0, 1'b1, 8'd0, 1'b0, !ok);
            end
            else if (cur_type == RT_BULK || cur_type == RT_VERBATIM) begin
                if (cur_type == RT_BULK && minus_one) begin
                    add_token(EV_HEADER, cur_type, val, 1'b1, 1'b1, 8'd0, 1'b0, 1'b0);
                end
                else if (!ok || negative || magnitude > LEN_MASK) begin
                    add_token(EV_HEADER, cur_type, val, 1'b0, 1'b1, 8'd0, 1'b0, 1'b1);
                end
                else begin
                    remaining = magnitude & LEN_MASK;
                    fmt_count = 0;
                    phase     = (remaining != 0) ? P_BODY : P_BODY_CR;
                    add_token(EV_HEADER, cur_type, val, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0);
                end
            end
            else if (cur_type == RT_ARRAY && minus_one) begin
                add_token(EV_HEADER, cur_type, val, 1'b1, 1'b1, 8'd0, 1'b0, 1'b0);
            end
            else begin
                add_token(EV_HEADER, cur_type, val, 1'b0, 1'b1, 8'd0, 1'b0,
                          !ok || negative);
            end
        endfunction

        // Advance the parse by one accepted stream byte.
        function void take_byte(logic [7:0] b);
            bit          is_digit;
            bit          known;
            bit          fmt;
            logic [63:0] d;
            logic [63:0] lim;
            rtype_e      rt;
            is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
            d        = {56'd0, b - CH_ZERO};
            case (phase)
                P_NUM_FIRST, P_NUM_SIGN, P_NUM_ZERO, P_NUM_DIGITS:
                begin
                    if (b == CH_CR) begin
                        if (phase == P_NUM_FIRST || phase == P_NUM_SIGN)
                            malformed = 1'b1;
                        phase = P_NUM_LF;
                    end
                    else if (malformed) begin
                        phase = P_NUM_DIGITS;
                    end
                    else if (phase == P_NUM_FIRST && b == CH_MINUS) begin
                        negative = 1'b1;
                        phase    = P_NUM_SIGN;
                    end
                    else if (phase == P_NUM_FIRST && b == CH_ZERO) begin
                        phase = P_NUM_ZERO;
                    end
                    else if (is_digit && phase != P_NUM_ZERO &&
                             (phase == P_NUM_DIGITS || d != 0)) begin
                        lim = negative ? NEG_MAX : POS_MAX;
                        if (magnitude > (lim - d) / 64'd10)
                            malformed = 1'b1;
                        else
                            magnitude = magnitude * 64'd10 + d;
                        phase = P_NUM_DIGITS;
                    end
                    else begin
                        malformed = 1'b1;
                        phase     = P_NUM_DIGITS;
                    end
                end
                P_NUM_LF:
                begin
                    close_number();
                end
                P_LINE:
                begin
                    if (b == CH_CR)
                        phase = P_LINE_LF;
                    else
                        add_token(EV_CONTENT, cur_type, 64'd0, 1'b0, 1'b0, b, 1'b0, 1'b0);
                end
                P_LINE_LF, P_BODY_LF:
                begin
                    phase = P_IDLE;
                    add_token(EV_REPLY_END, cur_type, 64'd0, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0);
                end
                P_TAIL_FIRST:
                begin
                    if (b == CH_CR) begin
                        phase = P_TAIL_LF;
                    end
                    else begin
                        saw_true = (b == CH_LOWER_T);
                        phase    = P_TAIL;
                    end
                end
                P_TAIL:
                begin
                    if (b == CH_CR)
                        phase = P_TAIL_LF;
                end
                P_TAIL_LF:
                begin
                    phase = P_IDLE;
                    add_token(EV_HEADER, cur_type,
                              (cur_type == RT_BOOL && saw_true) ? 64'd1 : 64'd0,
                              1'b0, 1'b1, 8'd0, 1'b0, 1'b0);
                end
                P_BODY:
                begin
                    fmt = (cur_type == RT_VERBATIM) && (fmt_count < 4);
                    if (fmt)
                        fmt_count++;
                    remaining = (remaining - 64'd1) & LEN_MASK;
                    if (remaining == 0)
                        phase = P_BODY_CR;
                    add_token(EV_CONTENT, cur_type, 64'd0, 1'b0, 1'b0, b, fmt, 1'b0);
                end
                P_BODY_CR:
                begin
                    phase = P_BODY_LF;
                end
                default:
                begin
                    phase = P_IDLE;
                    known = 1'b1;
                    rt    = RT_BULK;
                    case (b)
                        CH_DOLLAR:  rt = RT_BULK;
                        CH_PLUS:    rt = RT_SIMPLE;
                        CH_MINUS:   rt = RT_ERROR;
                        CH_COLON:   rt = RT_INTEGER;
                        CH_STAR:    rt = RT_ARRAY;
                        CH_TILDE:   rt = RT_SET;
                        CH_PERCENT: rt = RT_MAP;
                        CH_HASH:    rt = RT_BOOL;
                        CH_COMMA:   rt = RT_DOUBLE;
                        CH_UNDER:   rt = RT_NULL;
                        CH_LPAREN:  rt = RT_BIGNUM;
                        CH_EQUAL:   rt = RT_VERBATIM;
                        CH_PIPE:    rt = RT_ATTRIBUTE;
                        default:    known = 1'b0;
                    endcase
                    if (!known) begin
                        add_token(EV_BAD_TYPE, RT_BULK, 64'd0, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0);
                    end
                    else begin
                        cur_type  = rt;
                        magnitude = '0;
                        negative  = 1'b0;
                        malformed = 1'b0;
                        saw_true  = 1'b0;
                        case (rt)
                            RT_SIMPLE, RT_ERROR, RT_DOUBLE, RT_BIGNUM:
                            begin
                                phase = P_LINE;
                                add_token(EV_LINE_START, rt, 64'd0, 1'b0, 1'b0, 8'd0,
                                          1'b0, 1'b0);
                            end
                            RT_BOOL: phase = P_TAIL_FIRST;
                            RT_NULL: phase = P_TAIL;
                            default: phase = P_NUM_FIRST;
                        endcase
                    end
                end
            endcase
        endfunction

        task report_mismatch(string what);
            if (error_count < 50)
                $display("MISMATCH at %0t: %s", $time, what);
            error_count++;
        endtask

        // Compare one accepted event word with the oldest token due.
        task match_token(token_t seen);
            token_t exp;
            string  diffs;
            tokens_seen++;
            if (tokens_due.size() == 0) begin
                report_mismatch($sformatf("event %0d arrived with none due (ev %0d type %0d)",
                                          tokens_seen, seen.ev, seen.rt));
            end
            else begin
                exp   = tokens_due.pop_front();
                diffs = "";
                if (seen.ev !== exp.ev)               diffs = {diffs, " event_res"};
                if (seen.rt !== exp.rt)               diffs = {diffs, " reply_type"};
                if (seen.value !== exp.value)         diffs = {diffs, " header_value"};
                if (seen.nil !== exp.nil)             diffs = {diffs, " is_nil"};
                if (seen.completes !== exp.completes) diffs = {diffs, " header_completes"};
                if (seen.text !== exp.text)           diffs = {diffs, " content_byte"};
                if (seen.fmt !== exp.fmt)             diffs = {diffs, " in_format"};
                if (seen.bad !== exp.bad)             diffs = {diffs, " bad_number"};
                if (diffs != "")
                    report_mismatch($sformatf(
                        "event %0d bad%s: got %0d/%0d/%0d/%0b%0b/%h/%0b%0b want %0d/%0d/%0d/%0b%0b/%h/%0b%0b",
                        tokens_seen, diffs,
                        seen.ev, seen.rt, $signed(seen.value), seen.nil, seen.completes,
                        seen.text, seen.fmt, seen.bad,
                        exp.ev, exp.rt, $signed(exp.value), exp.nil, exp.completes,
                        exp.text, exp.fmt, exp.bad));
            end
        endtask

    endclass

endpackage

module tb_resp_reply_tokenizer_top;

    import rrt_pkg::*;
    import reply_token_pkg::*;

    // Run bounds. The cycle limit must cover the slowest legal run (every byte
    // behind a long source gap and every event behind a long sink stall, plus
    // the long hold).
    localparam int          CYCLE_LIMIT  = 1_000_000;
    localparam int          BYTE_TARGET  = 950;
    localparam int          HOLD_AT      = 300;
    localparam int          PAUSE_AT     = 600;
    localparam int          LONG_HOLD    = 400;
    localparam int          TAIL_CYCLES  = 16;
    localparam logic [7:0]  LF_BYTE      = 8'h0A;

    logic clk = 1'b0;
    logic rst_n;

    rrt_byte_if  stream_ch ();
    rrt_event_if event_ch ();

    resp_reply_tokenizer_top #(
        .LENGTH_BITS (LEN_BITS)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream_ch),
        .events (event_ch)
    );

    reply_token_tracker tracker = new();

    // Bytes of the reply being composed, sent oldest first.
    logic [7:0]  reply_bytes[$];
    int unsigned bytes_sent;
    bit          burst_mode;
    bit          hold_request;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // -----------------------------------------------------------------------
    // Monitors. Both sample at the rising edge, before any nonblocking update
    // of that edge lands, so they see exactly the values the block saw.
    // -----------------------------------------------------------------------

    // Feed every accepted stream word into the model.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && stream_ch.valid === 1'b1 && stream_ch.ready === 1'b1)
            tracker.take_byte(stream_ch.stream_byte);
    end

    // Check every accepted event word against the oldest token due.
    always @(posedge clk)
    begin
        token_t seen;
        if (rst_n === 1'b1 && event_ch.valid === 1'b1 && event_ch.ready === 1'b1) begin
            seen.ev        = event_ch.event_res;
            seen.rt        = event_ch.reply_type;
            seen.value     = event_ch.header_value;
            seen.nil       = event_ch.is_nil;
            seen.completes = event_ch.header_completes;
            seen.text      = event_ch.content_byte;
            seen.fmt       = event_ch.in_format;
            seen.bad       = event_ch.bad_number;
            tracker.match_token(seen);
        end
    end

    // Hard stop: count cycles and fail the run if it never finishes.
    initial
    begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // Idle length for either side: mostly none, some short, a few long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 16);
        else
            return $urandom_range(20, 60);
    endfunction

    // -----------------------------------------------------------------------
    // Event sink. Alternate ready runs with random stalls. On request, hold
    // ready low through LONG_HOLD so the output register fills and the block
    // has to stall its stream input.
    // -----------------------------------------------------------------------
    initial
    begin
        int unsigned run_len;
        int unsigned stall_len;
        event_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (hold_request) begin
                event_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_request = 1'b0;
            end
            else begin
                run_len = $urandom_range(1, 24);
                event_ch.ready <= 1'b1;
                repeat (run_len) @(posedge clk);
                stall_len = pick_gap();
                if (stall_len != 0) begin
                    event_ch.ready <= 1'b0;
                    repeat (stall_len) @(posedge clk);
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Stream source
    // -----------------------------------------------------------------------

    // Offer one word and hold it until the block takes it. Valid is only
    // dropped when a gap follows, so back-to-back words keep it high.
    task automatic send_byte(logic [7:0] b);
        int unsigned gap;
        gap = burst_mode ? 0 : pick_gap();
        if (gap != 0) begin
            stream_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        stream_ch.valid       <= 1'b1;
        stream_ch.stream_byte <= b;
        do
            @(posedge clk);
        while (stream_ch.ready !== 1'b1);
        bytes_sent++;
    endtask

    task automatic send_reply();
        foreach (reply_bytes[i])
            send_byte(reply_bytes[i]);
        reply_bytes.delete();
    endtask

    // Stop offering and wait until every event due has come out.
    task automatic drain_events();
        stream_ch.valid <= 1'b0;
        @(posedge clk);
        while (tracker.tokens_due.size() != 0)
            @(posedge clk);
    endtask

    // -----------------------------------------------------------------------
    // Reply composition
    // -----------------------------------------------------------------------

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++)
            reply_bytes.push_back(s[i]);
    endtask

    // CR and a closing byte; the block takes any byte there, so vary it.
    task automatic add_line_end();
        reply_bytes.push_back(CH_CR);
        reply_bytes.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : LF_BYTE);
    endtask

    function automatic logic [7:0] any_but_cr();
        logic [7:0] b;
        do
            b = 8'($urandom);
        while (b == CH_CR);
        return b;
    endfunction

    // Signed header value, weighted toward the corners of the 64-bit range.
    function automatic longint pick_value();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 64'sh7FFF_FFFF_FFFF_FFFF;
            2:       return 64'sh8000_0000_0000_0000;
            3:       return -1;
            4, 5:    return {$urandom, $urandom};
            default: return ($urandom_range(0, 1) == 1) ? -longint'($urandom_range(1, 999))
                                                        : longint'($urandom_range(0, 999));
        endcase
    endfunction

    // Number text that breaks the syntax or sits right at the range edges.
    function automatic string odd_number();
        case ($urandom_range(0, 13))
            0:       return "-0";
            1:       return "01";
            2:       return "";
            3:       return "-";
            4:       return "9223372036854775807";
            5:       return "-9223372036854775808";
            6:       return "9223372036854775808";
            7:       return "-9223372036854775809";
            8:       return "99999999999999999999";
            9:       return "12a4";
            10:      return "--1";
            11:      return "+5";
            12:      return "00";
            default: return "7 ";
        endcase
    endfunction

    // Build one reply: mostly well-formed with random content, some noise and
    // broken fragments that leave the parser mid-reply.
    task automatic compose_reply();
        logic [7:0]  line_types[4];
        logic [7:0]  agg_types[4];
        logic [7:0]  num_types[7];
        logic [7:0]  kind_byte;
        string       fmt_prefix;
        bit          prefixed;
        int unsigned kind;
        int unsigned len;
        logic [62:0] big;
        line_types = '{CH_PLUS, CH_MINUS, CH_COMMA, CH_LPAREN};
        agg_types  = '{CH_STAR, CH_TILDE, CH_PERCENT, CH_PIPE};
        num_types  = '{CH_COLON, CH_DOLLAR, CH_EQUAL, CH_STAR, CH_TILDE, CH_PERCENT, CH_PIPE};
        fmt_prefix = "txt:";
        kind       = $urandom_range(0, 99);
        if (kind < 5) begin
            // lone byte in idle, usually an unknown type
            reply_bytes.push_back(8'($urandom));
        end
        else if (kind < 24) begin
            // bulk or verbatim string, mostly short
            kind_byte = (kind < 17) ? CH_DOLLAR : CH_EQUAL;
            len       = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 48)
                                                    : $urandom_range(0, 8);
            prefixed  = ($urandom_range(0, 9) < 7);
            reply_bytes.push_back(kind_byte);
            add_text($sformatf("%0d", len));
            add_line_end();
            for (int i = 0; i < len; i++) begin
                if (kind_byte == CH_EQUAL && prefixed && i < 4 && len >= 4)
                    reply_bytes.push_back(fmt_prefix[i]);
                else
                    reply_bytes.push_back(8'($urandom));
            end
            if ($urandom_range(0, 99) < 85) begin
                reply_bytes.push_back(CH_CR);
                reply_bytes.push_back(LF_BYTE);
            end
            else begin
                reply_bytes.push_back(8'($urandom));
                reply_bytes.push_back(8'($urandom));
            end
        end
        else if (kind < 34) begin
            reply_bytes.push_back(CH_COLON);
            add_text($sformatf("%0d", pick_value()));
            add_line_end();
        end
        else if (kind < 42) begin
            // aggregate count: small, nil, negative or anything
            reply_bytes.push_back(agg_types[$urandom_range(0, 3)]);
            case ($urandom_range(0, 9))
                0:       add_text("-1");
                1:       add_text($sformatf("-%0d", $urandom_range(2, 1000)));
                2:       add_text($sformatf("%0d", pick_value()));
                default: add_text($sformatf("%0d", $urandom_range(0, 16)));
            endcase
            add_line_end();
        end
        else if (kind < 54) begin
            // simple, error, double and bignum text lines
            reply_bytes.push_back(line_types[$urandom_range(0, 3)]);
            repeat ($urandom_range(0, 10))
                reply_bytes.push_back(any_but_cr());
            add_line_end();
        end
        else if (kind < 60) begin
            // bool: 't', 'f', empty, or junk
            reply_bytes.push_back(CH_HASH);
            case ($urandom_range(0, 3))
                0: reply_bytes.push_back(CH_LOWER_T);
                1: add_text("f");
                2: ;
                default:
                    repeat ($urandom_range(1, 3))
                        reply_bytes.push_back(any_but_cr());
            endcase
            add_line_end();
        end
        else if (kind < 64) begin
            reply_bytes.push_back(CH_UNDER);
            repeat ($urandom_range(0, 2))
                reply_bytes.push_back(any_but_cr());
            add_line_end();
        end
        else if (kind < 70) begin
            // nil bulk string or nil array
            reply_bytes.push_back(($urandom_range(0, 1) == 1) ? CH_DOLLAR : CH_STAR);
            add_text("-1");
            add_line_end();
        end
        else if (kind < 76) begin
            // lengths beyond LENGTH_BITS or negative
            reply_bytes.push_back(($urandom_range(0, 1) == 1) ? CH_DOLLAR : CH_EQUAL);
            big = 63'({$urandom, $urandom});
            case ($urandom_range(0, 3))
                0:       add_text("4294967296");
                1:       add_text($sformatf("%0d", {1'b0, big | 63'h1_0000_0000}));
                2:       add_text("-1");
                default: add_text($sformatf("-%0d", $urandom_range(2, 99)));
            endcase
            add_line_end();
        end
        else if (kind < 90) begin
            reply_bytes.push_back(num_types[$urandom_range(0, 6)]);
            add_text(odd_number());
            add_line_end();
        end
        else begin
            // broken fragment: type bytes, digits and junk with no CR
            repeat ($urandom_range(1, 5)) begin
                case ($urandom_range(0, 3))
                    0:       reply_bytes.push_back(num_types[$urandom_range(0, 6)]);
                    1:       reply_bytes.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
                    default: reply_bytes.push_back(any_but_cr());
                endcase
            end
        end
    endtask

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------
    initial
    begin
        bit held;
        bit paused;
        rst_n                 = 1'b0;
        stream_ch.valid       = 1'b0;
        stream_ch.stream_byte = 8'h00;
        hold_request          = 1'b0;
        burst_mode            = 1'b0;
        bytes_sent            = 0;
        held                  = 1'b0;
        paused                = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed start: both extreme byte values as unknown types, an
        // empty bulk string, a true bool, a negative zero and a nil array.
        reply_bytes.push_back(8'h00);
        reply_bytes.push_back(8'hFF);
        add_text("$0");
        add_line_end();
        reply_bytes.push_back(CH_CR);
        reply_bytes.push_back(LF_BYTE);
        reply_bytes.push_back(CH_HASH);
        reply_bytes.push_back(CH_LOWER_T);
        add_line_end();
        add_text(":-0");
        add_line_end();
        add_text("*-1");
        add_line_end();
        send_reply();

        // Random replies. Partway through, hold the sink off for a long
        // stretch while the source keeps offering; later, pause the source
        // until every event due has come out.
        while (bytes_sent < BYTE_TARGET) begin
            if (!held && bytes_sent >= HOLD_AT) begin
                hold_request = 1'b1;
                held         = 1'b1;
            end
            if (!paused && bytes_sent >= PAUSE_AT) begin
                drain_events();
                paused = 1'b1;
            end
            burst_mode = ($urandom_range(0, 3) == 0);
            compose_reply();
            send_reply();
        end

        // Drain, then give the two-stage pipeline time to show any stray word.
        drain_events();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (tracker.error_count == 0 && tracker.tokens_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
